// ===== rtl/core/sac_pkg.sv =====
// shared constants and types for the set associative lru cache simulator
// no dependencies
package sac_pkg;

    localparam int MAX_SET_BITS_DEF = 6;
    localparam int MAX_WAYS_DEF     = 8;
    localparam int STAMP_WIDTH_DEF  = 32;

    localparam int TAG_W      = 62;
    localparam int ADDR_W     = 64;
    localparam int CNT_W      = 32;
    localparam int OFFSET_MAX = 32;

    localparam logic [1:0] OP_FETCH  = 2'd0;
    localparam logic [1:0] OP_LOAD   = 2'd1;
    localparam logic [1:0] OP_STORE  = 2'd2;
    localparam logic [1:0] OP_MODIFY = 2'd3;

    localparam logic [1:0] CFG_SET_BITS = 2'd0;
    localparam logic [1:0] CFG_WAYS     = 2'd1;
    localparam logic [1:0] CFG_OFFSET   = 2'd2;

    typedef struct packed {
        logic hit;
        logic evict;
    } lkp_status_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v, input logic en);
        sat_inc = (en && (v != {CNT_W{1'b1}})) ? v + CNT_W'(1) : v;
    endfunction

endpackage

// ===== rtl/core/sac_channels.sv =====
// request channel interfaces for trace items and result items
// depends on nothing
interface sac_trace_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [63:0] address;
    modport source (output valid, output op, output address, input ready);
    modport sink   (input valid, input op, input address, output ready);
endinterface

interface sac_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  hits_now;
    logic        missed_now;
    logic        evicted_now;
    logic [31:0] total_hits;
    logic [31:0] total_misses;
    logic [31:0] total_evictions;
    modport source (output valid, output hits_now, output missed_now, output evicted_now,
                    output total_hits, output total_misses, output total_evictions,
                    input ready);
    modport sink   (input valid, input hits_now, input missed_now, input evicted_now,
                    input total_hits, input total_misses, input total_evictions,
                    output ready);
endinterface

// ===== rtl/core/sac_row_mem.sv =====
// synchronous set memory, one row per set, one write and one registered read port
// no dependencies
module sac_row_mem #(
    parameter int ADDR_BITS = 6,
    parameter int DATA_BITS = 8
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [DATA_BITS-1:0] wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [DATA_BITS-1:0] rd_data
);
    logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

// ===== rtl/core/sac_lookup.sv =====
// tag compare across the ways of one set and lru victim pick
// depends on sac_pkg
module sac_lookup #(
    parameter int MAX_WAYS    = 8,
    parameter int STAMP_WIDTH = 32,
    parameter int WAY_W       = 3,
    parameter int WCNT_W      = 4
) (
    input  logic [MAX_WAYS-1:0]                  line_valid,
    input  logic [MAX_WAYS-1:0][61:0]            line_tag,
    input  logic [MAX_WAYS-1:0][STAMP_WIDTH-1:0] line_stamp,
    input  logic [61:0]                          tag,
    input  logic [WCNT_W-1:0]                    ways,
    output sac_pkg::lkp_status_t                 status,
    output logic [WAY_W-1:0]                     way
);
    import sac_pkg::*;

    logic                   hit;
    logic [WAY_W-1:0]       hit_way;
    logic [WAY_W-1:0]       pick;
    logic [STAMP_WIDTH-1:0] best;

    always_comb
    begin
        hit     = 1'b0;
        hit_way = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--)
        begin
            if (w < int'(ways) && line_valid[w] && line_tag[w] == tag)
            begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
        end
    end

    // strict less-than keeps the lowest way among equal stamps
    always_comb
    begin
        pick = '0;
        best = line_stamp[0];
        for (int w = 1; w < MAX_WAYS; w++)
        begin
            if (w < int'(ways) && line_stamp[w] < best)
            begin
                best = line_stamp[w];
                pick = WAY_W'(w);
            end
        end
    end

    assign status.hit   = hit;
    assign status.evict = !hit && line_valid[pick];
    assign way          = hit ? hit_way : pick;
endmodule

// ===== rtl/core/set_assoc_lru_cache_sim_unit.sv =====
// top level of the set associative lru cache simulator
// depends on sac_pkg, sac_channels, sac_row_mem, sac_lookup
//
//  channel  | role   | carries
//  ---------+--------+------------------------------------------------------
//  trace    | sink   | op, address
//  result   | source | hits_now, missed_now, evicted_now, three totals
//  cfg      | write  | cfg_we, cfg_index, cfg_data (no read-back)
//
// an item is accepted in S_IDLE, where the accept edge reads the set row from the row
// memory; S_LOOK compares tags, picks the lru way and writes the row back
// a modify makes its second access on the line just filled or hit, so it only counts
// reset clears the per-set row-written bits, so no clearing pass is needed
// a result waiting in the output register stalls the write-back, not the accept
module set_assoc_lru_cache_sim_unit #(
    parameter int MAX_SET_BITS = sac_pkg::MAX_SET_BITS_DEF,
    parameter int MAX_WAYS     = sac_pkg::MAX_WAYS_DEF,
    parameter int STAMP_WIDTH  = sac_pkg::STAMP_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    sac_trace_if.sink   trace,
    sac_result_if.source result,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [5:0]  cfg_data
);
    import sac_pkg::*;

    localparam int SETS   = 2 ** MAX_SET_BITS;
    localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WCNT_W = $clog2(MAX_WAYS + 1);
    localparam int SBIT_W = $clog2(MAX_SET_BITS + 1);
    localparam int LINE_W = 1 + TAG_W + STAMP_WIDTH;
    localparam int ROW_W  = MAX_WAYS * LINE_W;

    typedef enum logic {S_IDLE, S_LOOK} state_t;

    state_t state_reg;

    // configuration
    logic [2:0] set_bits_reg;
    logic [3:0] ways_reg;
    logic [5:0] offset_reg;

    // clamped geometry
    logic [SBIT_W-1:0] sbits_eff;
    logic [WCNT_W-1:0] ways_eff;
    logic [5:0]        obits_eff;

    // item in flight
    logic [1:0]              op_reg;
    logic [MAX_SET_BITS-1:0] set_reg;
    logic [TAG_W-1:0]        tag_reg;
    logic [CNT_W-1:0]        clock_reg;
    logic [SETS-1:0]         row_init_reg;

    logic [CNT_W-1:0] hit_total_reg;
    logic [CNT_W-1:0] miss_total_reg;
    logic [CNT_W-1:0] evict_total_reg;

    // output register
    logic        out_valid_reg;
    logic [1:0]  hits_now_reg;
    logic        missed_reg;
    logic        evicted_reg;

    logic                    accept;
    logic                    finish;
    logic [MAX_SET_BITS-1:0] set_in;
    logic [MAX_SET_BITS-1:0] set_mask;
    logic [TAG_W-1:0]        tag_in;
    logic [6:0]              tag_shift;
    logic [ROW_W-1:0]        rd_row;
    logic [ROW_W-1:0]        row_eff;
    logic [ROW_W-1:0]        row_next;
    logic [STAMP_WIDTH-1:0]  now;
    logic                    is_access;
    logic                    is_modify;

    logic [MAX_WAYS-1:0]                  v_vec;
    logic [MAX_WAYS-1:0][TAG_W-1:0]       t_vec;
    logic [MAX_WAYS-1:0][STAMP_WIDTH-1:0] s_vec;
    lkp_status_t                          lkp;
    logic [WAY_W-1:0]                     lkp_way;

    logic [CNT_W-1:0] hit_total_next;
    logic [CNT_W-1:0] hit_once;
    logic [CNT_W-1:0] miss_total_next;
    logic [CNT_W-1:0] evict_total_next;
    logic [1:0]       hits_now_next;

    // clamp the geometry into range
    always_comb
    begin
        if (set_bits_reg == 3'd0)
            sbits_eff = SBIT_W'(1);
        else if (int'(set_bits_reg) > MAX_SET_BITS)
            sbits_eff = SBIT_W'(MAX_SET_BITS);
        else
            sbits_eff = SBIT_W'(set_bits_reg);

        if (ways_reg == 4'd0)
            ways_eff = WCNT_W'(1);
        else if (int'(ways_reg) > MAX_WAYS)
            ways_eff = WCNT_W'(MAX_WAYS);
        else
            ways_eff = WCNT_W'(ways_reg);

        if (offset_reg == 6'd0)
            obits_eff = 6'd1;
        else if (int'(offset_reg) > OFFSET_MAX)
            obits_eff = 6'(OFFSET_MAX);
        else
            obits_eff = offset_reg;
    end

    // address split at accept
    assign set_mask  = ~({MAX_SET_BITS{1'b1}} << sbits_eff);
    assign set_in    = MAX_SET_BITS'(trace.address >> obits_eff) & set_mask;
    assign tag_shift = 7'(obits_eff) + 7'(sbits_eff);
    assign tag_in    = TAG_W'(trace.address >> tag_shift);

    assign trace.ready = (state_reg == S_IDLE);
    assign accept      = trace.valid && (state_reg == S_IDLE);
    // write-back waits until the output register has room
    assign finish      = (state_reg == S_LOOK) && (!out_valid_reg || result.ready);

    sac_row_mem #(
        .ADDR_BITS (MAX_SET_BITS),
        .DATA_BITS (ROW_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (finish && is_access),
        .wr_addr (set_reg),
        .wr_data (row_next),
        .rd_en   (accept),
        .rd_addr (set_in),
        .rd_data (rd_row)
    );

    // a row never written reads as all zero
    assign row_eff = row_init_reg[set_reg] ? rd_row : '0;

    always_comb
    begin
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            v_vec[w] = row_eff[w*LINE_W + TAG_W + STAMP_WIDTH];
            t_vec[w] = row_eff[w*LINE_W + STAMP_WIDTH +: TAG_W];
            s_vec[w] = row_eff[w*LINE_W +: STAMP_WIDTH];
        end
    end

    sac_lookup #(
        .MAX_WAYS    (MAX_WAYS),
        .STAMP_WIDTH (STAMP_WIDTH),
        .WAY_W       (WAY_W),
        .WCNT_W      (WCNT_W)
    ) u_lookup (
        .line_valid (v_vec),
        .line_tag   (t_vec),
        .line_stamp (s_vec),
        .tag        (tag_reg),
        .ways       (ways_eff),
        .status     (lkp),
        .way        (lkp_way)
    );

    assign now       = STAMP_WIDTH'(clock_reg);
    assign is_access = (op_reg != OP_FETCH);
    assign is_modify = (op_reg == OP_MODIFY);

    // hit refreshes the stamp, miss installs the tag in the victim way
    always_comb
    begin
        row_next = row_eff;
        row_next[int'(lkp_way)*LINE_W +: LINE_W] = {1'b1, tag_reg, now};
    end

    // modify's second access always hits
    always_comb
    begin
        hit_once         = sat_inc(hit_total_reg, is_access && lkp.hit);
        hit_total_next   = sat_inc(hit_once, is_modify);
        miss_total_next  = sat_inc(miss_total_reg, is_access && !lkp.hit);
        evict_total_next = sat_inc(evict_total_reg, is_access && lkp.evict);
        hits_now_next    = 2'((is_access && lkp.hit) ? 1 : 0) + 2'(is_modify ? 1 : 0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            set_bits_reg    <= 3'd4;
            ways_reg        <= 4'd1;
            offset_reg      <= 6'd4;
            clock_reg       <= '0;
            row_init_reg    <= '0;
            hit_total_reg   <= '0;
            miss_total_reg  <= '0;
            evict_total_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SET_BITS: set_bits_reg <= cfg_data[2:0];
                    CFG_WAYS:     ways_reg     <= cfg_data[3:0];
                    CFG_OFFSET:   offset_reg   <= cfg_data;
                    default:      ;
                endcase
            end

            // a new result loads as the old one leaves
            if (finish)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && result.ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg    <= trace.op;
                        set_reg   <= set_in;
                        tag_reg   <= tag_in;
                        clock_reg <= clock_reg + CNT_W'(1);
                        state_reg <= S_LOOK;
                    end
                end
                S_LOOK:
                begin
                    if (finish)
                    begin
                        if (is_access)
                            row_init_reg[set_reg] <= 1'b1;
                        hit_total_reg   <= hit_total_next;
                        miss_total_reg  <= miss_total_next;
                        evict_total_reg <= evict_total_next;
                        hits_now_reg    <= hits_now_next;
                        missed_reg      <= is_access && !lkp.hit;
                        evicted_reg     <= is_access && lkp.evict;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.hits_now        = hits_now_reg;
    assign result.missed_now      = missed_reg;
    assign result.evicted_now     = evicted_reg;
    assign result.total_hits      = hit_total_reg;
    assign result.total_misses    = miss_total_reg;
    assign result.total_evictions = evict_total_reg;
endmodule

// ===== test/set_assoc_lru_cache_sim_unit_tb.sv =====
// testbench for the set associative lru cache simulator: directed table, then random
// traffic under bursts and stalls, every result checked against a behavioral cache model
// depends on sac_pkg, sac_channels and the rtl top level
module set_assoc_lru_cache_sim_unit_tb;
    import sac_pkg::*;

    localparam int N_SETS  = 1 << MAX_SET_BITS_DEF;
    localparam int N_LINES = N_SETS * MAX_WAYS_DEF;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [1:0]  hits_now;
        logic        missed_now;
        logic        evicted_now;
        logic [31:0] total_hits;
        logic [31:0] total_misses;
        logic [31:0] total_evictions;
    } tally_t;

    // one directed row: known marks a result that is typed in
    typedef struct {
        logic [1:0]  op;
        logic [63:0] address;
        bit          known;
        tally_t      want;
    } trace_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic [1:0] cfg_index = CFG_SET_BITS;
    logic [5:0] cfg_data = '0;

    sac_trace_if  trace ();
    sac_result_if result ();

    set_assoc_lru_cache_sim_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .trace     (trace.sink),
        .result    (result.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // cache model state
    logic [61:0] tag_mem   [N_LINES];
    bit          valid_mem [N_LINES];
    logic [31:0] stamp_mem [N_LINES];
    logic [31:0] trace_clock;
    logic [31:0] hit_sum, miss_sum, evict_sum;
    logic [2:0]  geo_set_bits;
    logic [3:0]  geo_ways;
    logic [5:0]  geo_offset;

    tally_t tally_queue[$];
    int     fail_count = 0;
    int     cycle_count = 0;
    bit     long_hold = 1'b0;

    function automatic logic [31:0] bump(logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    // one access; returns 0 hit, 1 miss, 2 miss with eviction
    function automatic int cache_access(logic [63:0] address);
        int sb, nw, ob, base, pick;
        logic [63:0] set_sel;
        logic [61:0] tag;
        sb = (geo_set_bits == 0) ? 1 : (geo_set_bits > MAX_SET_BITS_DEF ? MAX_SET_BITS_DEF
                                                                           : geo_set_bits);
        nw = (geo_ways == 0) ? 1 : (geo_ways > MAX_WAYS_DEF ? MAX_WAYS_DEF : geo_ways);
        ob = (geo_offset == 0) ? 1 : (geo_offset > OFFSET_MAX ? OFFSET_MAX : geo_offset);
        set_sel = (address >> ob) & ((64'd1 << sb) - 64'd1);
        tag = 62'(address >> (ob + sb));
        base = int'(set_sel) * MAX_WAYS_DEF;
        for (int w = 0; w < nw; w++)
            if (valid_mem[base+w] && tag_mem[base+w] == tag)
            begin
                stamp_mem[base+w] = trace_clock;
                hit_sum = bump(hit_sum);
                return 0;
            end
        miss_sum = bump(miss_sum);
        pick = 0;
        for (int w = 1; w < nw; w++)
            if (stamp_mem[base+w] < stamp_mem[base+pick])
                pick = w;
        cache_access = valid_mem[base+pick] ? 2 : 1;
        if (valid_mem[base+pick])
            evict_sum = bump(evict_sum);
        tag_mem[base+pick]   = tag;
        stamp_mem[base+pick] = trace_clock;
        valid_mem[base+pick] = 1'b1;
    endfunction

    function automatic tally_t predict_tally(logic [1:0] op, logic [63:0] address);
        tally_t t;
        int r;
        t = '0;
        trace_clock = trace_clock + 32'd1;
        if (op != OP_FETCH)
        begin
            r = cache_access(address);
            if (r == 0)
                t.hits_now = 2'd1;
            else
                t.missed_now = 1'b1;
            t.evicted_now = (r == 2);
            if (op == OP_MODIFY && cache_access(address) == 0)
                t.hits_now = t.hits_now + 2'd1;
        end
        t.total_hits      = hit_sum;
        t.total_misses    = miss_sum;
        t.total_evictions = evict_sum;
        return t;
    endfunction

    task automatic model_reset();
        foreach (tag_mem[i])
        begin
            tag_mem[i] = '0;
            valid_mem[i] = 1'b0;
            stamp_mem[i] = '0;
        end
        trace_clock = '0;
        hit_sum = '0;
        miss_sum = '0;
        evict_sum = '0;
        geo_set_bits = 3'd4;
        geo_ways = 4'd1;
        geo_offset = 6'd4;
    endtask

    // cycle limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("set_assoc_lru_cache_sim_unit regression: fail");
            $finish;
        end
    end

    // receiver: own stall pattern, plus one long hold-off on request
    initial
    begin
        int held;
        result.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                result.ready <= 1'b0;
                for (held = 0; held < 60; held++)
                    @(posedge clk);
                long_hold = 1'b0;
            end
            case ($urandom_range(0, 3))
                0: result.ready <= ($urandom_range(0, 3) == 0);
                default: result.ready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    // result checker, sampled at the edge
    always @(posedge clk)
    begin
        tally_t got, exp_t;
        if (rst_n && result.valid && result.ready)
        begin
            got = '{result.hits_now, result.missed_now, result.evicted_now,
                    result.total_hits, result.total_misses, result.total_evictions};
            if (tally_queue.size() == 0)
            begin
                $display("%0t: unexpected request on result, actual %h", $time, got);
                fail_count++;
            end
            else
            begin
                exp_t = tally_queue.pop_front();
                if (got.hits_now !== exp_t.hits_now || got.missed_now !== exp_t.missed_now ||
                    got.evicted_now !== exp_t.evicted_now ||
                    got.total_hits !== exp_t.total_hits ||
                    got.total_misses !== exp_t.total_misses ||
                    got.total_evictions !== exp_t.total_evictions)
                begin
                    $display("%0t: result mismatch, expected %h actual %h", $time, exp_t, got);
                    fail_count++;
                end
            end
        end
    end

    // offer one request and hold it until taken
    task automatic send_item(logic [1:0] op, logic [63:0] address);
        trace.valid   <= 1'b1;
        trace.op      <= op;
        trace.address <= address;
        do @(posedge clk); while (!trace.ready);
        tally_queue.push_back(predict_tally(op, address));
    endtask

    task automatic idle_sender(int n);
        trace.valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // wait until every result is in, then let the pipeline drain
    task automatic drain();
        trace.valid <= 1'b0;
        while (tally_queue.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] index, logic [5:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (index)
            CFG_SET_BITS: geo_set_bits = value[2:0];
            CFG_WAYS:     geo_ways     = value[3:0];
            default:      geo_offset   = value;
        endcase
    endtask

    // random address: mostly a small pool of tags so hits and evictions happen
    function automatic logic [63:0] pick_address(logic [63:0] pool[$]);
        if ($urandom_range(0, 9) < 8)
            return pool[$urandom_range(0, pool.size() - 1)] ^ 64'($urandom_range(0, 15));
        return {$urandom, $urandom};
    endfunction

    task automatic random_phase(int count);
        logic [63:0] pool[$];
        int sent, burst;
        for (int i = 0; i < 12; i++)
            pool.push_back({$urandom, $urandom});
        sent = 0;
        while (sent < count)
        begin
            burst = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 8);
            for (int k = 0; k < burst && sent < count; k++, sent++)
                send_item(2'($urandom_range(0, 3)), pick_address(pool));
            if ($urandom_range(0, 2) != 0)
                idle_sender($urandom_range(1, 6));
        end
    endtask

    trace_row_t directed[$];

    initial
    begin
        trace_row_t row;
        trace.valid = 1'b0;
        trace.op = OP_FETCH;
        trace.address = '0;
        model_reset();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset geometry: 16 sets, 1 way, 16-byte blocks
        directed = '{
            '{OP_FETCH,  64'h0, 1'b1, '{2'd0, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0}},
            '{OP_LOAD,   64'h0, 1'b1, '{2'd0, 1'b1, 1'b0, 32'd0, 32'd1, 32'd0}},
            '{OP_LOAD,   64'hF, 1'b1, '{2'd1, 1'b0, 1'b0, 32'd1, 32'd1, 32'd0}},
            '{OP_STORE,  64'h100, 1'b1, '{2'd0, 1'b1, 1'b1, 32'd1, 32'd2, 32'd1}},
            '{OP_MODIFY, 64'h0, 1'b1, '{2'd1, 1'b1, 1'b1, 32'd2, 32'd3, 32'd2}},
            '{OP_MODIFY, 64'h4, 1'b1, '{2'd2, 1'b0, 1'b0, 32'd4, 32'd3, 32'd2}},
            '{OP_LOAD,   64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
            '{OP_STORE,  64'hFFFF_FFFF_FFFF_FFF0, 1'b0, '0},
            '{OP_FETCH,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
            '{OP_MODIFY, 64'h5555_AAAA_5555_AAAA, 1'b0, '0},
            '{OP_MODIFY, 64'hAAAA_5555_AAAA_5555, 1'b0, '0}
        };
        foreach (directed[i])
        begin
            row = directed[i];
            send_item(row.op, row.address);
            if (row.known && tally_queue[$] != row.want)
            begin
                $display("%0t: table row %0d expected %h model %h", $time, i, row.want,
                         tally_queue[$]);
                fail_count++;
            end
        end
        drain();

        // out-of-range register values clamp: zero and max encodings
        write_reg(CFG_SET_BITS, 6'd0);
        write_reg(CFG_WAYS, 6'd0);
        write_reg(CFG_OFFSET, 6'd0);
        for (int i = 0; i < 6; i++)
            send_item(2'($urandom_range(1, 3)), 64'(i * 2));
        drain();
        write_reg(CFG_SET_BITS, 6'd7);
        write_reg(CFG_WAYS, 6'd15);
        write_reg(CFG_OFFSET, 6'd63);
        // eight ways filled then further tags evict the least recently used
        for (int i = 0; i < 10; i++)
            send_item(OP_LOAD, {26'(i), 38'h0});
        send_item(OP_LOAD, 64'h0);
        drain();

        // long receiver hold-off while the sender keeps offering
        long_hold = 1'b1;
        random_phase(120);
        drain();

        // geometry sweep, stored lines kept across changes
        write_reg(CFG_SET_BITS, 6'd1);
        write_reg(CFG_WAYS, 6'd8);
        write_reg(CFG_OFFSET, 6'd1);
        random_phase(150);
        drain();
        write_reg(CFG_SET_BITS, 6'd6);
        write_reg(CFG_WAYS, 6'd2);
        write_reg(CFG_OFFSET, 6'd32);
        random_phase(150);
        drain();
        write_reg(CFG_SET_BITS, 6'd3);
        write_reg(CFG_WAYS, 6'd4);
        write_reg(CFG_OFFSET, 6'd5);
        random_phase(150);
        // pause until every result is in, then continue
        drain();
        random_phase(100);
        drain();

        if (fail_count == 0)
            $display("set_assoc_lru_cache_sim_unit regression: pass");
        else
            $display("set_assoc_lru_cache_sim_unit regression: fail");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/core/sac_pkg.sv
rtl/core/sac_channels.sv
rtl/core/sac_row_mem.sv
rtl/core/sac_lookup.sv
rtl/core/set_assoc_lru_cache_sim_unit.sv
test/set_assoc_lru_cache_sim_unit_tb.sv
